[rtl/i2c_master_command_engine_defines.svh]
// Assertion macros used by the I2C master command engine checker.
`ifndef I2C_MASTER_COMMAND_ENGINE_DEFINES_SVH
`define I2C_MASTER_COMMAND_ENGINE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define I2C_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define I2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/i2c_mce_pkg.sv]
// Package with command codes, state encoding and step tables of the I2C command engine.
package i2c_mce_pkg;

   localparam int unsigned KindWidth = 4;

   // Request kind codes.
   localparam logic [KindWidth-1:0] KIND_TICK           = 4'd0;
   localparam logic [KindWidth-1:0] KIND_START          = 4'd1;
   localparam logic [KindWidth-1:0] KIND_STOP           = 4'd2;
   localparam logic [KindWidth-1:0] KIND_WRITE_BYTE     = 4'd3;
   localparam logic [KindWidth-1:0] KIND_READ_BYTE      = 4'd4;
   localparam logic [KindWidth-1:0] KIND_SEND_ACK       = 4'd5;
   localparam logic [KindWidth-1:0] KIND_READ_ACK       = 4'd6;
   localparam logic [KindWidth-1:0] KIND_WAIT_ACK       = 4'd7;
   localparam logic [KindWidth-1:0] KIND_READ_BYTE_ACK  = 4'd8;

   localparam logic [7:0] RETRY_LIMIT_RESET = 8'd250;

   // Active command, one-hot.
   typedef enum logic [8:0] {
      CMD_IDLE          = 9'b000000001,
      CMD_START         = 9'b000000010,
      CMD_STOP          = 9'b000000100,
      CMD_WRITE_BYTE    = 9'b000001000,
      CMD_READ_BYTE     = 9'b000010000,
      CMD_SEND_ACK      = 9'b000100000,
      CMD_READ_ACK      = 9'b001000000,
      CMD_WAIT_ACK      = 9'b010000000,
      CMD_READ_BYTE_ACK = 9'b100000000
   } cmd_type;

   // Step position split into bit number and phase (step / 3 and step % 3).
   localparam logic [3:0] DIV3_TABLE [32] = '{
      4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
      4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5,
      4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7,
      4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10
   };

   localparam logic [1:0] MOD3_TABLE [32] = '{
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
      2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
      2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
   };

   localparam logic [1:0] PHASE_DRIVE  = 2'd0;
   localparam logic [1:0] PHASE_MIDDLE = 2'd1;

endpackage

[rtl/i2c_master_command_engine.sv]
// Top level of the I2C master command engine: command latch, pin sequencer and result register.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+----------------------------------------
//   req_    | in        | req_tvalid/req_tready | tuser kind, tdata write/ack/sda_in
//   rsp_    | out       | rsp_tvalid/rsp_tready | tdata pin levels, status, read byte
//   csr_    | in        | csr_tvalid/csr_tready | tdata ack retry limit
//
// Every request produces exactly one response, valid in the cycle after it is accepted. The
// whole pin action for a request is computed between the state registers and the response
// register, so a new request is taken every cycle while the response slot is free or is
// being drained. A stalled response holds req_tready low until rsp_tready returns.
// Synchronous active-high reset releases both lines, returns to idle and restores the
// retry limit of 250; outside reset the retry limit register is written on any csr_tvalid.
module i2c_master_command_engine (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] write_data, [8] ack_drive, [9] sda_in, rest zero
   input  logic [3:0]  req_tuser,  // [3:0] kind
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
                                   // [11:4] read_data, [12] ack_seen, [13] timed_out,
                                   // [14] rejected, [15] zero
   // Configuration write channel.
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata   // [7:0] ack_retry_limit
);

   // Request fields.
   logic [3:0] req_kind;
   logic [7:0] req_write_data;
   logic       req_ack_drive;
   logic       req_sda_in;

   assign req_kind       = req_tuser;
   assign req_write_data = req_tdata[7:0];
   assign req_ack_drive  = req_tdata[8];
   assign req_sda_in     = req_tdata[9];

   logic req_accept;

   // Engine state.
   i2c_mce_pkg::cmd_type cmd_ff, cmd_in;
   logic       scl_ff, scl_in;
   logic       sda_lvl_ff, sda_lvl_in;
   logic [4:0] step_ff, step_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] retry_ff, retry_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       last_ack_ff, last_ack_in;
   logic [7:0] read_hold_ff, read_hold_in;
   logic [7:0] retry_limit_ff;

   // Response register.
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0] rsp_tdata_ff, rsp_tdata_in;

   // Per-request flags.
   logic fin;
   logic timeout;
   logic rej;

   // Step decode. The read byte sequence counts its bits from one step later.
   logic [4:0] step_less_one;
   logic [2:0] bit_now;
   logic [1:0] phase_now;
   logic [2:0] bit_late;
   logic [1:0] phase_late;
   logic [8:0] retry_next;

   assign step_less_one = step_ff - 5'd1;
   assign bit_now       = i2c_mce_pkg::DIV3_TABLE[step_ff][2:0];
   assign phase_now     = i2c_mce_pkg::MOD3_TABLE[step_ff];
   assign bit_late      = i2c_mce_pkg::DIV3_TABLE[step_less_one][2:0];
   assign phase_late    = i2c_mce_pkg::MOD3_TABLE[step_less_one];
   assign retry_next    = {1'b0, retry_ff} + 9'd1;

   // The response slot empties as it is taken, so a request may enter in the same cycle.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_tready = 1'b1;

   always_comb begin
      cmd_in        = cmd_ff;
      scl_in        = scl_ff;
      sda_lvl_in    = sda_lvl_ff;
      step_in       = step_ff;
      shift_in      = shift_ff;
      retry_in      = retry_ff;
      ack_choice_in = ack_choice_ff;
      last_ack_in   = last_ack_ff;
      read_hold_in  = read_hold_ff;
      fin           = 1'b0;
      timeout       = 1'b0;
      rej           = 1'b0;

      if (req_accept && (req_kind == i2c_mce_pkg::KIND_TICK)) begin
         if (cmd_ff != i2c_mce_pkg::CMD_IDLE) begin
            step_in = step_ff + 5'd1;
            unique case (cmd_ff)
               i2c_mce_pkg::CMD_START: begin
                  // SDA high, SCL high, SDA falls while SCL is high, SCL low.
                  if (step_ff == 5'd0) begin
                     sda_lvl_in = 1'b1;
                  end else if (step_ff == 5'd1) begin
                     scl_in = 1'b1;
                  end else if (step_ff == 5'd2) begin
                     sda_lvl_in = 1'b0;
                  end else begin
                     scl_in = 1'b0;
                     fin    = 1'b1;
                  end
               end
               i2c_mce_pkg::CMD_STOP: begin
                  if (step_ff == 5'd0) begin
                     sda_lvl_in = 1'b0;
                  end else if (step_ff == 5'd1) begin
                     scl_in = 1'b1;
                  end else begin
                     sda_lvl_in = 1'b1;
                     fin        = 1'b1;
                  end
               end
               i2c_mce_pkg::CMD_WRITE_BYTE: begin
                  if (phase_now == i2c_mce_pkg::PHASE_DRIVE) begin
                     sda_lvl_in = shift_ff[3'd7 - bit_now];
                  end else if (phase_now == i2c_mce_pkg::PHASE_MIDDLE) begin
                     scl_in = 1'b1;
                  end else begin
                     scl_in = 1'b0;
                     fin    = (step_ff >= 5'd23);
                  end
               end
               i2c_mce_pkg::CMD_READ_BYTE: begin
                  if (step_ff == 5'd0) begin
                     sda_lvl_in = 1'b1;
                  end else if (phase_late == i2c_mce_pkg::PHASE_DRIVE) begin
                     scl_in = 1'b1;
                  end else if (phase_late == i2c_mce_pkg::PHASE_MIDDLE) begin
                     if (req_sda_in) begin
                        shift_in[3'd7 - bit_late] = 1'b1;
                     end
                  end else begin
                     scl_in = 1'b0;
                     if (step_ff >= 5'd24) begin
                        fin          = 1'b1;
                        read_hold_in = shift_ff;
                     end
                  end
               end
               i2c_mce_pkg::CMD_SEND_ACK: begin
                  if (step_ff == 5'd0) begin
                     sda_lvl_in = ack_choice_ff;
                  end else if (step_ff == 5'd1) begin
                     scl_in = 1'b1;
                  end else begin
                     scl_in = 1'b0;
                     fin    = 1'b1;
                  end
               end
               i2c_mce_pkg::CMD_READ_ACK: begin
                  if (step_ff == 5'd0) begin
                     sda_lvl_in = 1'b1;
                  end else if (step_ff == 5'd1) begin
                     scl_in = 1'b1;
                  end else if (step_ff == 5'd2) begin
                     last_ack_in = req_sda_in;
                  end else begin
                     scl_in = 1'b0;
                     fin    = 1'b1;
                  end
               end
               i2c_mce_pkg::CMD_WAIT_ACK: begin
                  // Step two polls SDA; a low level goes to step three, a timeout to the
                  // stop sequence in steps four to six.
                  if (step_ff == 5'd0) begin
                     sda_lvl_in = 1'b1;
                  end else if (step_ff == 5'd1) begin
                     scl_in = 1'b1;
                  end else if (step_ff == 5'd2) begin
                     if (!req_sda_in) begin
                        step_in = 5'd3;
                     end else if (retry_next > {1'b0, retry_limit_ff}) begin
                        step_in = 5'd4;
                     end else begin
                        retry_in = retry_next[7:0];
                        step_in  = 5'd2;
                     end
                  end else if (step_ff == 5'd3) begin
                     scl_in      = 1'b0;
                     last_ack_in = 1'b0;
                     fin         = 1'b1;
                  end else if (step_ff == 5'd4) begin
                     sda_lvl_in = 1'b0;
                  end else if (step_ff == 5'd5) begin
                     scl_in = 1'b1;
                  end else begin
                     sda_lvl_in  = 1'b1;
                     last_ack_in = 1'b1;
                     timeout     = 1'b1;
                     fin         = 1'b1;
                  end
               end
               i2c_mce_pkg::CMD_READ_BYTE_ACK: begin
                  if (step_ff < 5'd24) begin
                     if (phase_now == i2c_mce_pkg::PHASE_DRIVE) begin
                        scl_in = 1'b0;
                     end else if (phase_now == i2c_mce_pkg::PHASE_MIDDLE) begin
                        scl_in = 1'b1;
                     end else begin
                        shift_in = {shift_ff[6:0], req_sda_in};
                     end
                  end else if (step_ff == 5'd24) begin
                     scl_in = 1'b0;
                  end else if (step_ff == 5'd25) begin
                     sda_lvl_in = !ack_choice_ff;
                  end else if (step_ff == 5'd26) begin
                     scl_in = 1'b1;
                  end else begin
                     scl_in       = 1'b0;
                     fin          = 1'b1;
                     read_hold_in = shift_ff;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
            if (fin) begin
               cmd_in  = i2c_mce_pkg::CMD_IDLE;
               step_in = 5'd0;
            end
         end
      end else if (req_accept && (req_kind <= i2c_mce_pkg::KIND_READ_BYTE_ACK)) begin
         if (cmd_ff != i2c_mce_pkg::CMD_IDLE) begin
            // A new command while one is running is dropped and flagged.
            rej = 1'b1;
         end else begin
            unique case (req_kind)
               i2c_mce_pkg::KIND_START:      cmd_in = i2c_mce_pkg::CMD_START;
               i2c_mce_pkg::KIND_STOP:       cmd_in = i2c_mce_pkg::CMD_STOP;
               i2c_mce_pkg::KIND_WRITE_BYTE: cmd_in = i2c_mce_pkg::CMD_WRITE_BYTE;
               i2c_mce_pkg::KIND_READ_BYTE:  cmd_in = i2c_mce_pkg::CMD_READ_BYTE;
               i2c_mce_pkg::KIND_SEND_ACK:   cmd_in = i2c_mce_pkg::CMD_SEND_ACK;
               i2c_mce_pkg::KIND_READ_ACK:   cmd_in = i2c_mce_pkg::CMD_READ_ACK;
               i2c_mce_pkg::KIND_WAIT_ACK:   cmd_in = i2c_mce_pkg::CMD_WAIT_ACK;
               default:                      cmd_in = i2c_mce_pkg::CMD_READ_BYTE_ACK;
            endcase
            step_in  = 5'd0;
            retry_in = 8'd0;
            shift_in = (req_kind == i2c_mce_pkg::KIND_WRITE_BYTE) ? req_write_data : 8'd0;
            if ((req_kind == i2c_mce_pkg::KIND_SEND_ACK) ||
                (req_kind == i2c_mce_pkg::KIND_READ_BYTE_ACK)) begin
               ack_choice_in = req_ack_drive;
            end
         end
      end
      // Kinds above eight leave the state alone and still get a response.
   end

   // The response slot loads on every accepted request and clears when taken.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (req_accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, rej, timeout, last_ack_in, read_hold_in, fin,
                          (cmd_in != i2c_mce_pkg::CMD_IDLE), sda_lvl_in, scl_in};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff         <= i2c_mce_pkg::CMD_IDLE;
         scl_ff         <= 1'b1;
         sda_lvl_ff     <= 1'b1;
         step_ff        <= 5'd0;
         shift_ff       <= 8'd0;
         retry_ff       <= 8'd0;
         ack_choice_ff  <= 1'b0;
         last_ack_ff    <= 1'b0;
         read_hold_ff   <= 8'd0;
         retry_limit_ff <= i2c_mce_pkg::RETRY_LIMIT_RESET;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         cmd_ff        <= cmd_in;
         scl_ff        <= scl_in;
         sda_lvl_ff    <= sda_lvl_in;
         step_ff       <= step_in;
         shift_ff      <= shift_in;
         retry_ff      <= retry_in;
         ack_choice_ff <= ack_choice_in;
         last_ack_ff   <= last_ack_in;
         read_hold_ff  <= read_hold_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_tvalid && csr_tready) begin
            retry_limit_ff <= csr_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[rtl/i2c_mce_checker.sv]
// Port-level checker for the I2C master command engine and its bind statement.
`include "i2c_master_command_engine_defines.svh"

module i2c_mce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled response keeps its contents.
   `I2C_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // Each accepted request yields a response in the next cycle.
   `I2C_ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready, rsp_tvalid, "no response after an accepted request")

   // A completed command leaves the engine idle.
   `I2C_ASSERT_SAME(a_done_idle, clock, reset, rsp_tvalid && rsp_tdata[3], !rsp_tdata[2], "done reported while still busy")

   // A timeout ends with a stop: both lines released, NACK seen, command done.
   `I2C_ASSERT_SAME(a_timeout_stop, clock, reset, rsp_tvalid && rsp_tdata[13], rsp_tdata[0] && rsp_tdata[1] && rsp_tdata[3] && rsp_tdata[12], "timeout without a stop and NACK")

   // A rejected command can only happen while the engine is busy.
   `I2C_ASSERT_SAME(a_reject_busy, clock, reset, rsp_tvalid && rsp_tdata[14], rsp_tdata[2] && !rsp_tdata[3], "command rejected while idle")

endmodule

bind i2c_master_command_engine i2c_mce_checker u_i2c_mce_checker (.*);

[tb/i2c_master_command_engine_tb.sv]
// Self-checking testbench for the I2C master command engine, with a directed table and random command sequences.
module i2c_master_command_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The watchdog gives up after this many cycles in which no channel moves anything.
   // The longest quiet stretch of a correct run is the deliberate response hold-off.
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned HOLD_AFTER  = 500;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned SEGMENT_ITEMS = 170;

   // Response word as it appears on rsp_tdata, from the top bit down.
   typedef struct packed {
      logic       spare;
      logic       rejected;
      logic       timed_out;
      logic       ack_seen;
      logic [7:0] read_data;
      logic       done;
      logic       busy;
      logic       sda;
      logic       scl;
   } line_response_type;

   // One row of the directed table. A row with a repeat count above one sends the
   // same request that many times. When typed is set, the response is spelled out.
   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  wdata;
      logic        ackd;
      logic        sda;
      logic [7:0]  reps;
      logic        typed;
      logic [15:0] rsp;
   } plan_row_type;

   localparam int unsigned PLAN_ROWS = 26;

   // Each accepted command but the last is finished by exactly the ticks that follow it,
   // so it leaves the engine idle. The first rows cover the idle and ignored cases.
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // A tick while idle changes nothing: both lines released, not busy.
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b0, 8'd1,  1'b1, 16'h0003},
      // Kinds above eight change no state but still get a response, even with every bit set.
      '{4'hF,                            8'hFF, 1'b1, 1'b1, 8'd1,  1'b1, 16'h0003},
      '{4'h9,                            8'h00, 1'b0, 1'b0, 8'd1,  1'b1, 16'h0003},
      // A start latches without moving a pin; write data on it is ignored.
      '{i2c_mce_pkg::KIND_START,         8'hA5, 1'b1, 1'b1, 8'd1,  1'b1, 16'h0007},
      // A command while busy is refused and the sequence stays put.
      '{i2c_mce_pkg::KIND_WRITE_BYTE,    8'h3C, 1'b0, 1'b0, 8'd1,  1'b1, 16'h4007},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b0, 8'd4,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_WRITE_BYTE,    8'hFF, 1'b1, 1'b1, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b1, 8'd24, 1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_WRITE_BYTE,    8'h00, 1'b0, 1'b0, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b0, 8'd24, 1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_READ_BYTE,     8'hFF, 1'b1, 1'b0, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b1, 8'd25, 1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_READ_BYTE_ACK, 8'h00, 1'b1, 1'b0, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b0, 8'd28, 1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_READ_BYTE_ACK, 8'hFF, 1'b0, 1'b1, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b1, 1'b1, 8'd28, 1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_SEND_ACK,      8'h00, 1'b1, 1'b0, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b0, 8'd3,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_READ_ACK,      8'h00, 1'b0, 1'b0, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b1, 8'd4,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_WAIT_ACK,      8'h00, 1'b0, 1'b0, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b0, 8'd4,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_STOP,          8'h00, 1'b0, 1'b0, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b0, 8'd3,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_TICK,          8'h00, 1'b0, 1'b1, 8'd1,  1'b0, 16'h0000},
      '{i2c_mce_pkg::KIND_SEND_ACK,      8'h00, 1'b0, 1'b0, 8'd1,  1'b0, 16'h0000}
   };

   // Every input has a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [7:0]  csr_tdata = '0;

   // Chances, in percent, that the sender or the receiver sits out a cycle.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   // Responses that the engine still owes, oldest first.
   line_response_type owed_responses [$];

   // Shadow of the engine's state and of its retry limit register.
   logic       bus_scl;
   logic       bus_sda;
   logic [3:0] active_kind;
   logic [4:0] step;
   logic [7:0] shift_reg;
   logic [7:0] retries;
   logic       ack_level;
   logic       ack_flag;
   logic [7:0] held_byte;
   logic [7:0] retry_limit;

   // A wait ack marked stuck sees SDA high on every sample, which forces a timeout.
   bit wait_stuck = 1'b0;

   always #2 clock = ~clock;

   i2c_master_command_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   task automatic clear_shadow();
      bus_scl     = 1'b1;
      bus_sda     = 1'b1;
      active_kind = i2c_mce_pkg::KIND_TICK;
      step        = '0;
      shift_reg   = '0;
      retries     = '0;
      ack_level   = 1'b0;
      ack_flag    = 1'b0;
      held_byte   = '0;
      retry_limit = i2c_mce_pkg::RETRY_LIMIT_RESET;
   endtask

   // Carries out one pin action of the active command. Returns 1 when the command
   // completes; sets timeout when a wait ack gave up and sent its stop.
   function automatic logic advance_sequence(input logic sda_in, output logic timeout);
      int unsigned pos;
      int unsigned nxt;
      int unsigned bit_no;
      int unsigned phase;
      logic fin;
      pos = step;
      nxt = pos + 1;
      fin = 1'b0;
      timeout = 1'b0;
      case (active_kind)
         i2c_mce_pkg::KIND_START: begin
            if (pos == 0) bus_sda = 1'b1;
            else if (pos == 1) bus_scl = 1'b1;
            else if (pos == 2) bus_sda = 1'b0;
            else begin
               bus_scl = 1'b0;
               fin = 1'b1;
            end
         end
         i2c_mce_pkg::KIND_STOP: begin
            if (pos == 0) bus_sda = 1'b0;
            else if (pos == 1) bus_scl = 1'b1;
            else begin
               bus_sda = 1'b1;
               fin = 1'b1;
            end
         end
         i2c_mce_pkg::KIND_WRITE_BYTE: begin
            // Three steps per bit, most significant bit first.
            bit_no = (pos / 3) % 8;
            phase = pos % 3;
            if (phase == 0) bus_sda = shift_reg[7 - bit_no];
            else if (phase == 1) bus_scl = 1'b1;
            else begin
               bus_scl = 1'b0;
               if (pos >= 23) fin = 1'b1;
            end
         end
         i2c_mce_pkg::KIND_READ_BYTE: begin
            if (pos == 0) bus_sda = 1'b1;
            else begin
               bit_no = ((pos - 1) / 3) % 8;
               phase = (pos - 1) % 3;
               if (phase == 0) bus_scl = 1'b1;
               else if (phase == 1) begin
                  if (sda_in) shift_reg[7 - bit_no] = 1'b1;
               end else begin
                  bus_scl = 1'b0;
                  if (pos >= 24) begin
                     fin = 1'b1;
                     held_byte = shift_reg;
                  end
               end
            end
         end
         i2c_mce_pkg::KIND_SEND_ACK: begin
            if (pos == 0) bus_sda = ack_level;
            else if (pos == 1) bus_scl = 1'b1;
            else begin
               bus_scl = 1'b0;
               fin = 1'b1;
            end
         end
         i2c_mce_pkg::KIND_READ_ACK: begin
            if (pos == 0) bus_sda = 1'b1;
            else if (pos == 1) bus_scl = 1'b1;
            else if (pos == 2) ack_flag = sda_in;
            else begin
               bus_scl = 1'b0;
               fin = 1'b1;
            end
         end
         i2c_mce_pkg::KIND_WAIT_ACK: begin
            // Step two repeats while SDA stays high and the retry budget lasts;
            // steps four to six are the stop that follows a timeout.
            if (pos == 0) bus_sda = 1'b1;
            else if (pos == 1) bus_scl = 1'b1;
            else if (pos == 2) begin
               if (!sda_in) nxt = 3;
               else if (int'(retries) + 1 > int'(retry_limit)) nxt = 4;
               else begin
                  retries = retries + 8'd1;
                  nxt = 2;
               end
            end else if (pos == 3) begin
               bus_scl = 1'b0;
               ack_flag = 1'b0;
               fin = 1'b1;
            end else if (pos == 4) bus_sda = 1'b0;
            else if (pos == 5) bus_scl = 1'b1;
            else begin
               bus_sda = 1'b1;
               ack_flag = 1'b1;
               timeout = 1'b1;
               fin = 1'b1;
            end
         end
         i2c_mce_pkg::KIND_READ_BYTE_ACK: begin
            // Eight clocked samples shifted in from the right, then the ack bit.
            if (pos < 24) begin
               phase = pos % 3;
               if (phase == 0) bus_scl = 1'b0;
               else if (phase == 1) bus_scl = 1'b1;
               else shift_reg = {shift_reg[6:0], sda_in};
            end else if (pos == 24) bus_scl = 1'b0;
            else if (pos == 25) bus_sda = ack_level ? 1'b0 : 1'b1;
            else if (pos == 26) bus_scl = 1'b1;
            else begin
               bus_scl = 1'b0;
               fin = 1'b1;
               held_byte = shift_reg;
            end
         end
         default: fin = 1'b1;
      endcase
      step = nxt[4:0];
      if (fin) begin
         active_kind = i2c_mce_pkg::KIND_TICK;
         step = '0;
      end
      return fin;
   endfunction

   // Applies one accepted request to the shadow state and returns the response it causes.
   function automatic line_response_type predict_line_response(input logic [3:0] kind,
                                                               input logic [7:0] wdata,
                                                               input logic ackd,
                                                               input logic sda_in);
      line_response_type rsp;
      logic done;
      logic timeout;
      done = 1'b0;
      timeout = 1'b0;
      rsp = '0;
      if (kind == i2c_mce_pkg::KIND_TICK) begin
         if (active_kind != i2c_mce_pkg::KIND_TICK) done = advance_sequence(sda_in, timeout);
      end else if (kind <= i2c_mce_pkg::KIND_READ_BYTE_ACK) begin
         if (active_kind != i2c_mce_pkg::KIND_TICK) rsp.rejected = 1'b1;
         else begin
            active_kind = kind;
            step = '0;
            retries = '0;
            shift_reg = (kind == i2c_mce_pkg::KIND_WRITE_BYTE) ? wdata : 8'h00;
            if (kind == i2c_mce_pkg::KIND_SEND_ACK || kind == i2c_mce_pkg::KIND_READ_BYTE_ACK)
               ack_level = ackd;
         end
      end
      rsp.scl = bus_scl;
      rsp.sda = bus_sda;
      rsp.busy = (active_kind != i2c_mce_pkg::KIND_TICK);
      rsp.done = done;
      rsp.read_data = held_byte;
      rsp.ack_seen = ack_flag;
      rsp.timed_out = timeout;
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      $display("MISMATCH at %0t: %s, expected %0h, got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   // Offers one request, holding it until the engine takes it, and records what the
   // engine owes for it. A typed response replaces the prediction, but the shadow
   // state still moves so that later rows are predicted correctly.
   task automatic offer_request(input logic [3:0] kind, input logic [7:0] wdata,
                                input logic ackd, input logic sda_in,
                                input logic typed, input logic [15:0] typed_rsp);
      line_response_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b000000, sda_in, ackd, wdata};
      do @(posedge clock); while (!req_tready);
      predicted = predict_line_response(kind, wdata, ackd, sda_in);
      owed_responses.push_back(typed ? line_response_type'(typed_rsp) : predicted);
   endtask

   // The limit is only changed once every owed response has come back.
   task automatic program_retry_limit(input logic [7:0] limit);
      req_tvalid <= 1'b0;
      while (owed_responses.size() != 0) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= limit;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      retry_limit = limit;
   endtask

   // Mostly whole command sequences with random content. Some idle ticks, unknown
   // kinds and refused commands are mixed in as noise. The segment always ends idle.
   task automatic run_command_sequences(input int unsigned items);
      int unsigned counted;
      logic [3:0] kind;
      logic sda_in;
      counted = 0;
      while (counted < items || active_kind != i2c_mce_pkg::KIND_TICK) begin
         if (active_kind == i2c_mce_pkg::KIND_TICK) begin
            if ($urandom_range(99) < 6) begin
               offer_request(i2c_mce_pkg::KIND_TICK, 8'($urandom), 1'($urandom),
                             1'($urandom), 1'b0, '0);
            end else if ($urandom_range(99) < 6) begin
               kind = 4'($urandom_range(15, 9));
               offer_request(kind, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
            end else begin
               kind = 4'($urandom_range(8, 1));
               // A timeout under a large limit takes hundreds of ticks, so it is rarer there.
               wait_stuck = ($urandom_range(99) < ((retry_limit > 8'd16) ? 8 : 40));
               offer_request(kind, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
               counted++;
            end
         end else if ($urandom_range(99) < 4) begin
            kind = 4'($urandom_range(8, 1));
            offer_request(kind, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
            counted++;
         end else begin
            // While a wait ack samples, SDA is mostly high so that retries pile up.
            if (active_kind == i2c_mce_pkg::KIND_WAIT_ACK && step == 5'd2)
               sda_in = wait_stuck ? 1'b1 : ($urandom_range(99) < 75);
            else
               sda_in = 1'($urandom);
            offer_request(i2c_mce_pkg::KIND_TICK, 8'($urandom), 1'($urandom), sda_in,
                          1'b0, '0);
            counted++;
         end
      end
   endtask

   // Receiver. Once a few hundred responses have gone by, it refuses responses for a
   // long stretch while the sender keeps offering, so the engine backs up and stalls.
   always @(posedge clock) begin
      static int unsigned taken = 0;
      static int unsigned hold_left = 0;
      static bit held = 1'b0;
      if (rsp_tvalid && rsp_tready) taken++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held && taken >= HOLD_AFTER) begin
         held = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Response checker: each response is matched field by field to the oldest one owed.
   always @(posedge clock) begin
      line_response_type got;
      line_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (owed_responses.size() == 0) begin
            report_mismatch("response with none owed", 16'h0000, got);
         end else begin
            want = owed_responses.pop_front();
            if (got.scl !== want.scl) report_mismatch("scl_out", want, got);
            if (got.sda !== want.sda) report_mismatch("sda_out", want, got);
            if (got.busy !== want.busy) report_mismatch("busy_res", want, got);
            if (got.done !== want.done) report_mismatch("done_res", want, got);
            if (got.read_data !== want.read_data) report_mismatch("read_data", want, got);
            if (got.ack_seen !== want.ack_seen) report_mismatch("ack_seen", want, got);
            if (got.timed_out !== want.timed_out) report_mismatch("timed_out", want, got);
            if (got.rejected !== want.rejected) report_mismatch("rejected", want, got);
            if (got.spare !== want.spare) report_mismatch("unused top bit", want, got);
         end
      end
   end

   // Watchdog: a correct engine never goes this long without moving something.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired at %0t", $realtime);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Retry limits for the random segments: both extremes, small values that make
   // timeouts cheap, one random value, and the reset value again at the end.
   logic [7:0] segment_limits [6];

   initial begin
      clear_shadow();
      segment_limits = '{8'd0, 8'd255, 8'd1, 8'($urandom), 8'd2,
                         i2c_mce_pkg::RETRY_LIMIT_RESET};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs with the reset value of the retry limit.
      req_idle_pct = 31;
      rsp_idle_pct = 49;
      for (int r = 0; r < PLAN_ROWS; r++) begin
         for (int n = 0; n < int'(DIRECTED_PLAN[r].reps); n++)
            offer_request(DIRECTED_PLAN[r].kind, DIRECTED_PLAN[r].wdata,
                          DIRECTED_PLAN[r].ackd, DIRECTED_PLAN[r].sda,
                          DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].rsp);
      end
      // The last row leaves a send ack running; finish it before moving on.
      while (active_kind != i2c_mce_pkg::KIND_TICK)
         offer_request(i2c_mce_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0);

      // Two segments per idling pattern: receiver-heavy gaps, then sender-heavy, then none.
      for (int s = 0; s < 6; s++) begin
         req_idle_pct = (s < 2) ? 31 : (s < 4) ? 49 : 0;
         rsp_idle_pct = (s < 2) ? 49 : (s < 4) ? 31 : 0;
         program_retry_limit(segment_limits[s]);
         run_command_sequences(SEGMENT_ITEMS);
      end
      req_tvalid <= 1'b0;

      while (owed_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
